@@ rtl/sfd_pkg.sv @@
// Shared constants, types and CRC helpers for the sync frame deframer.
package sfd_pkg;

  localparam int FRAME_LEN = 24;
  localparam int IDX_W     = $clog2(FRAME_LEN);
  localparam int BYTE_W    = 8;
  localparam int POS_W     = 6;
  localparam int CRC_W     = 16;
  localparam int CNT_W     = 3;

  localparam logic [BYTE_W-1:0] SYNC_A   = 8'h5A;
  localparam logic [BYTE_W-1:0] SYNC_B   = 8'h44;
  localparam logic [CRC_W-1:0]  CRC_POLY = 16'h8005;
  localparam logic [CRC_W-1:0]  CRC_INIT = 16'h0000;
  localparam logic [CRC_W-1:0]  CRC_TOP  = 16'h8000;

  localparam logic [IDX_W-1:0] IDX_HDR0    = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_HDR1    = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_AFTER   = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_CRC_END = IDX_W'(FRAME_LEN - 2);
  localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(FRAME_LEN - 1);

  localparam logic [CNT_W-1:0] CNT_FIRST = 3'd0;
  localparam logic [CNT_W-1:0] CNT_SECOND = 3'd1;
  localparam logic [CNT_W-1:0] CNT_LAST  = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CRC  = 4'b0010,
    ST_READ = 4'b0100,
    ST_SHOW = 4'b1000
  } state_t;

  // One MSB-first shift of the CRC register.
  function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] c);
    logic [CRC_W-1:0] s;
    s = {c[CRC_W-2:0], 1'b0};
    if ((c & CRC_TOP) != CRC_INIT) begin
      s = s ^ CRC_POLY;
    end
    return s;
  endfunction

  // Whole-byte update, used only for elaboration-time constants.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < BYTE_W; i++) begin
      c = crc_step(c);
    end
    return c;
  endfunction

  localparam logic [CRC_W-1:0] CRC_SYNC = crc_byte(crc_byte(CRC_INIT, SYNC_A), SYNC_B);

endpackage

@@ rtl/sfd_if.sv @@
// Valid/ready channel interfaces for received bytes and emitted frame bytes.
interface sfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [5:0] byte_position;
  logic       frame_last;

  modport source (output valid, output frame_byte, output byte_position,
                  output frame_last, input ready);
  modport sink   (input valid, input frame_byte, input byte_position,
                  input frame_last, output ready);
endinterface

@@ rtl/sync_frame_deframer_crc16_unit.sv @@
// Sync-header deframer with bit-serial CRC-16 check and frame replay.
// Each received byte is accepted in the idle state and then run through the
// one-bit-per-cycle CRC shifter; in_chan.ready is high only when idle.
// A byte that completes a good frame then replays it, each output beat
// taking a store read state, then a present state, plus any output stall.
// Reset (rst_n low, synchronous) clears the sequencer, fill count and CRC;
// frame store entries stay undefined until written.
module sync_frame_deframer_crc16_unit (
  input  logic clk,
  input  logic rst_n,
  sfd_rx_if.sink   in_chan,
  sfd_tx_if.source out_chan
);

  sfd_pkg::state_t state_r, state_nxt;
  logic [sfd_pkg::IDX_W-1:0]  fill_r, fill_nxt;
  logic [sfd_pkg::CRC_W-1:0]  crc_r, crc_nxt;
  logic [sfd_pkg::CRC_W-1:0]  shift_r, shift_nxt;
  logic [sfd_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [sfd_pkg::BYTE_W-1:0] last_r, last_nxt;
  logic [sfd_pkg::BYTE_W-1:0] prev_r, prev_nxt;
  logic                       restart_r, restart_nxt;
  logic                       hdr_ok_r, hdr_ok_nxt;
  logic [sfd_pkg::IDX_W-1:0]  rd_idx_r, rd_idx_nxt;

  logic [sfd_pkg::BYTE_W-1:0] store_mem [sfd_pkg::FRAME_LEN];
  logic [sfd_pkg::BYTE_W-1:0] rd_data_r;
  logic                       mem_we;
  logic [sfd_pkg::IDX_W-1:0]  mem_waddr;
  logic [sfd_pkg::BYTE_W-1:0] mem_wdata;
  logic [sfd_pkg::CRC_W-1:0]  shift_step;

  assign shift_step = sfd_pkg::crc_step(shift_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= store_mem[rd_idx_r];
  end

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    crc_nxt     = crc_r;
    shift_nxt   = shift_r;
    cnt_nxt     = cnt_r;
    last_nxt    = last_r;
    prev_nxt    = prev_r;
    restart_nxt = restart_r;
    hdr_ok_nxt  = hdr_ok_r;
    rd_idx_nxt  = rd_idx_r;
    mem_we      = 1'b0;
    mem_waddr   = fill_r;
    mem_wdata   = in_chan.rx_byte;

    case (state_r)
      sfd_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          mem_we      = 1'b1;
          prev_nxt    = last_r;
          last_nxt    = in_chan.rx_byte;
          restart_nxt = (fill_r != sfd_pkg::IDX_HDR0) && (last_r == sfd_pkg::SYNC_A) &&
                        (in_chan.rx_byte == sfd_pkg::SYNC_B);
          shift_nxt   = ((fill_r == sfd_pkg::IDX_HDR0) ? sfd_pkg::CRC_INIT : crc_r) ^
                        {in_chan.rx_byte, 8'h00};
          if (fill_r == sfd_pkg::IDX_HDR0) begin
            hdr_ok_nxt = 1'b0;
          end
          cnt_nxt   = sfd_pkg::CNT_FIRST;
          state_nxt = sfd_pkg::ST_CRC;
        end
      end

      sfd_pkg::ST_CRC: begin
        shift_nxt = shift_step;
        cnt_nxt   = cnt_r + 1'b1;
        // Restart rewrites the header into the first two slots.
        if (restart_r && cnt_r == sfd_pkg::CNT_FIRST) begin
          mem_we    = 1'b1;
          mem_waddr = sfd_pkg::IDX_HDR0;
          mem_wdata = sfd_pkg::SYNC_A;
        end
        if (restart_r && cnt_r == sfd_pkg::CNT_SECOND) begin
          mem_we    = 1'b1;
          mem_waddr = sfd_pkg::IDX_HDR1;
          mem_wdata = sfd_pkg::SYNC_B;
        end
        if (cnt_r == sfd_pkg::CNT_LAST) begin
          state_nxt = sfd_pkg::ST_IDLE;
          if (restart_r) begin
            crc_nxt    = sfd_pkg::CRC_SYNC;
            fill_nxt   = sfd_pkg::IDX_AFTER;
            hdr_ok_nxt = 1'b1;
          end else if (fill_r == sfd_pkg::IDX_LAST) begin
            fill_nxt = sfd_pkg::IDX_HDR0;
            // Trailer is little-endian: second to last byte low.
            if (hdr_ok_r && ({last_r, prev_r} == crc_r)) begin
              rd_idx_nxt = sfd_pkg::IDX_HDR0;
              state_nxt  = sfd_pkg::ST_READ;
            end
          end else begin
            fill_nxt = fill_r + 1'b1;
            if (fill_r < sfd_pkg::IDX_CRC_END) begin
              crc_nxt = shift_step;
            end
          end
        end
      end

      sfd_pkg::ST_READ: begin
        state_nxt = sfd_pkg::ST_SHOW;
      end

      sfd_pkg::ST_SHOW: begin
        if (out_chan.ready) begin
          if (rd_idx_r == sfd_pkg::IDX_LAST) begin
            state_nxt = sfd_pkg::ST_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
            state_nxt  = sfd_pkg::ST_READ;
          end
        end
      end

      default: begin
        state_nxt = sfd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sfd_pkg::ST_IDLE;
      fill_r    <= sfd_pkg::IDX_HDR0;
      crc_r     <= sfd_pkg::CRC_INIT;
      cnt_r     <= sfd_pkg::CNT_FIRST;
      restart_r <= 1'b0;
      hdr_ok_r  <= 1'b0;
      rd_idx_r  <= sfd_pkg::IDX_HDR0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      crc_r     <= crc_nxt;
      cnt_r     <= cnt_nxt;
      restart_r <= restart_nxt;
      hdr_ok_r  <= hdr_ok_nxt;
      rd_idx_r  <= rd_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    last_r  <= last_nxt;
    prev_r  <= prev_nxt;
  end

  assign in_chan.ready          = (state_r == sfd_pkg::ST_IDLE);
  assign out_chan.valid         = (state_r == sfd_pkg::ST_SHOW);
  assign out_chan.frame_byte    = rd_data_r;
  assign out_chan.byte_position = sfd_pkg::POS_W'(rd_idx_r);
  assign out_chan.frame_last    = (rd_idx_r == sfd_pkg::IDX_LAST);

endmodule

@@ tb/sv/sync_frame_deframer_crc16_unit_test.sv @@
// Self-checking testbench for the sync-header deframer with CRC-16 frame check.
`timescale 1ns / 100ps

module sync_frame_deframer_crc16_unit_test;

  localparam int RANDOM_ITEMS  = 335;
  localparam int LONG_HOLD     = 600;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int MAX_REPORTS   = 10;
  localparam int PAYLOAD_LEN   = sfd_pkg::FRAME_LEN - 4;

  typedef enum logic [1:0] {TK_BYTE, TK_CRC_LO, TK_CRC_HI} tok_kind_t;
  typedef enum logic {EXP_NONE, EXP_PREDICT} want_t;

  // For CRC tokens, val is an xor mask applied to the running CRC byte.
  typedef struct packed {
    tok_kind_t   kind;
    logic [7:0]  val;
    want_t       want;
  } rx_token_t;

  typedef struct packed {
    logic [7:0] data;
    logic [5:0] pos;
    logic       last;
  } frame_beat_t;

  typedef enum int {
    SEQ_GOOD, SEQ_BAD_CRC, SEQ_HDR_AT_END, SEQ_MID_RESTART, SEQ_BAD_HDR, SEQ_NOISE
  } seq_kind_t;

  // One stray byte after reset, then a good frame whose payload holds lone sync bytes.
  localparam rx_token_t GOOD_FRAME_ROWS [25] = '{
    '{TK_BYTE, 8'h00, EXP_NONE}, '{TK_BYTE, 8'h5A, EXP_NONE}, '{TK_BYTE, 8'h44, EXP_NONE},
    '{TK_BYTE, 8'hFF, EXP_NONE}, '{TK_BYTE, 8'h00, EXP_NONE}, '{TK_BYTE, 8'h5A, EXP_NONE},
    '{TK_BYTE, 8'h5A, EXP_NONE}, '{TK_BYTE, 8'h45, EXP_NONE}, '{TK_BYTE, 8'h44, EXP_NONE},
    '{TK_BYTE, 8'h80, EXP_NONE}, '{TK_BYTE, 8'h01, EXP_NONE}, '{TK_BYTE, 8'h7F, EXP_NONE},
    '{TK_BYTE, 8'hFE, EXP_NONE}, '{TK_BYTE, 8'h55, EXP_NONE}, '{TK_BYTE, 8'hAA, EXP_NONE},
    '{TK_BYTE, 8'h5A, EXP_NONE}, '{TK_BYTE, 8'h00, EXP_NONE}, '{TK_BYTE, 8'h44, EXP_NONE},
    '{TK_BYTE, 8'h0F, EXP_NONE}, '{TK_BYTE, 8'hF0, EXP_NONE}, '{TK_BYTE, 8'h5B, EXP_NONE},
    '{TK_BYTE, 8'h43, EXP_NONE}, '{TK_BYTE, 8'h3C, EXP_NONE},
    '{TK_CRC_LO, 8'h00, EXP_NONE}, '{TK_CRC_HI, 8'h00, EXP_PREDICT}
  };

  logic clk;
  logic rst_n = 1'b0;

  sfd_rx_if in_chan();
  sfd_tx_if out_chan();

  sync_frame_deframer_crc16_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  logic [7:0]  mirror_store [sfd_pkg::FRAME_LEN];
  int unsigned mirror_fill;
  logic [15:0] mirror_crc;

  frame_beat_t frame_bytes_due[$];
  rx_token_t   planned_bytes[$];

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit          hold_request;
  int unsigned hold_left;
  int          mismatches;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    repeat (8) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ sfd_pkg::CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // Advance the mirrored deframer by one byte; return the frame bytes it releases.
  function automatic void deframe_step(input logic [7:0] b, output frame_beat_t beats[$]);
    int unsigned pos;
    logic [15:0] rx_crc;
    beats = {};
    if (mirror_fill >= sfd_pkg::FRAME_LEN) mirror_fill = 0;
    pos = mirror_fill;
    mirror_store[pos] = b;
    if (pos == 0) mirror_crc = sfd_pkg::CRC_INIT;
    if (pos < sfd_pkg::FRAME_LEN - 2) mirror_crc = crc16_next(mirror_crc, b);
    mirror_fill = pos + 1;
    if (mirror_fill >= 2 && mirror_store[mirror_fill-2] == sfd_pkg::SYNC_A &&
        mirror_store[mirror_fill-1] == sfd_pkg::SYNC_B) begin
      mirror_store[0] = sfd_pkg::SYNC_A;
      mirror_store[1] = sfd_pkg::SYNC_B;
      mirror_fill = 2;
      mirror_crc = crc16_next(crc16_next(sfd_pkg::CRC_INIT, sfd_pkg::SYNC_A), sfd_pkg::SYNC_B);
    end
    if (mirror_fill >= sfd_pkg::FRAME_LEN) begin
      rx_crc = {mirror_store[sfd_pkg::FRAME_LEN-1], mirror_store[sfd_pkg::FRAME_LEN-2]};
      if (mirror_store[0] == sfd_pkg::SYNC_A && mirror_store[1] == sfd_pkg::SYNC_B &&
          rx_crc == mirror_crc) begin
        for (int k = 0; k < sfd_pkg::FRAME_LEN; k++) begin
          beats.push_back('{data: mirror_store[k], pos: 6'(k),
                            last: (k == sfd_pkg::FRAME_LEN - 1)});
        end
      end
      mirror_fill = 0;
    end
  endfunction

  function automatic logic [7:0] clean_byte();
    logic [7:0] v;
    v = 8'($urandom_range(255));
    return (v == sfd_pkg::SYNC_B) ? (v ^ 8'h01) : v;
  endfunction

  function automatic void queue_byte(input logic [7:0] v);
    planned_bytes.push_back('{kind: TK_BYTE, val: v, want: EXP_PREDICT});
  endfunction

  function automatic void queue_frame(input logic [15:0] crc_flip);
    queue_byte(sfd_pkg::SYNC_A);
    queue_byte(sfd_pkg::SYNC_B);
    repeat (PAYLOAD_LEN) queue_byte(clean_byte());
    planned_bytes.push_back('{kind: TK_CRC_LO, val: crc_flip[7:0], want: EXP_PREDICT});
    planned_bytes.push_back('{kind: TK_CRC_HI, val: crc_flip[15:8], want: EXP_PREDICT});
  endfunction

  // Plan one byte sequence; the mirror must already hold every earlier byte.
  function automatic void plan_sequence(input seq_kind_t kind);
    logic [7:0] b0;
    case (kind)
      SEQ_GOOD:    queue_frame(16'h0000);
      SEQ_BAD_CRC: queue_frame(16'h0001 << $urandom_range(15));
      SEQ_HDR_AT_END: begin
        queue_byte(sfd_pkg::SYNC_A);
        queue_byte(sfd_pkg::SYNC_B);
        repeat (PAYLOAD_LEN) queue_byte(clean_byte());
        queue_byte(sfd_pkg::SYNC_A);
        queue_byte(sfd_pkg::SYNC_B);
      end
      SEQ_MID_RESTART: begin
        queue_byte(sfd_pkg::SYNC_A);
        queue_byte(sfd_pkg::SYNC_B);
        repeat ($urandom_range(PAYLOAD_LEN - 1)) queue_byte(clean_byte());
        queue_frame(16'h0000);
      end
      SEQ_BAD_HDR: begin
        // Pad up to a frame boundary so the broken header lands at position zero.
        repeat ((sfd_pkg::FRAME_LEN - mirror_fill) % sfd_pkg::FRAME_LEN)
          queue_byte(clean_byte());
        if ($urandom_range(1) == 0) begin
          b0 = clean_byte();
          queue_byte((b0 == sfd_pkg::SYNC_A) ? ~sfd_pkg::SYNC_A : b0);
          queue_byte(sfd_pkg::SYNC_B);
        end else begin
          queue_byte(sfd_pkg::SYNC_A);
          queue_byte(sfd_pkg::SYNC_B ^ (8'h01 << $urandom_range(7)));
        end
        repeat (PAYLOAD_LEN) queue_byte(clean_byte());
        planned_bytes.push_back('{kind: TK_CRC_LO, val: 8'h00, want: EXP_PREDICT});
        planned_bytes.push_back('{kind: TK_CRC_HI, val: 8'h00, want: EXP_PREDICT});
      end
      default: repeat ($urandom_range(30, 1)) queue_byte(8'($urandom_range(255)));
    endcase
  endfunction

  function automatic seq_kind_t pick_sequence();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return SEQ_GOOD;
    if (r < 52) return SEQ_BAD_CRC;
    if (r < 64) return SEQ_HDR_AT_END;
    if (r < 76) return SEQ_MID_RESTART;
    if (r < 88) return SEQ_BAD_HDR;
    return SEQ_NOISE;
  endfunction

  task automatic drive_token(input rx_token_t t);
    logic [7:0]  b;
    frame_beat_t beats[$];
    while ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    case (t.kind)
      TK_CRC_LO: b = mirror_crc[7:0] ^ t.val;
      TK_CRC_HI: b = mirror_crc[15:8] ^ t.val;
      default:   b = t.val;
    endcase
    in_chan.valid   <= 1'b1;
    in_chan.rx_byte <= b;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    deframe_step(b, beats);
    if (t.want == EXP_PREDICT) begin
      foreach (beats[i]) frame_bytes_due.push_back(beats[i]);
    end
  endtask

  // Sender.
  initial begin
    int unsigned random_sent;
    int          phase;
    in_chan.valid   <= 1'b0;
    in_chan.rx_byte <= 8'h00;
    mirror_fill  = 0;
    mirror_crc   = sfd_pkg::CRC_INIT;
    hold_request = 1'b0;
    tx_idle_pct  = 26;
    rx_idle_pct  = 46;
    random_sent  = 0;
    phase        = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (GOOD_FRAME_ROWS[i]) drive_token(GOOD_FRAME_ROWS[i]);

    while (random_sent < RANDOM_ITEMS || planned_bytes.size() != 0) begin
      if (phase == 0 && random_sent >= RANDOM_ITEMS / 3) begin
        phase = 1;
        // Drain every pending frame before swapping the idle rates.
        in_chan.valid <= 1'b0;
        @(posedge clk);
        while (frame_bytes_due.size() != 0) @(posedge clk);
        tx_idle_pct = 46;
        rx_idle_pct = 26;
      end else if (phase == 1 && random_sent >= 2 * RANDOM_ITEMS / 3) begin
        phase = 2;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_request = 1'b1;
        queue_frame(16'h0000);
        queue_frame(16'h0000);
      end
      if (planned_bytes.size() == 0) plan_sequence(pick_sequence());
      drive_token(planned_bytes.pop_front());
      random_sent++;
    end

    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    out_chan.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial mismatches = 0;

  always @(posedge clk) begin : beat_check
    frame_beat_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (frame_bytes_due.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected beat: byte %02h pos %0d last %0b",
                   out_chan.frame_byte, out_chan.byte_position, out_chan.frame_last);
        end
      end else begin
        want = frame_bytes_due.pop_front();
        if (out_chan.frame_byte !== want.data || out_chan.byte_position !== want.pos ||
            out_chan.frame_last !== want.last) begin
          mismatches = mismatches + 1;
          if (mismatches <= MAX_REPORTS) begin
            $display("beat mismatch: expected byte %02h pos %0d last %0b, got %02h %0d %0b",
                     want.data, want.pos, want.last, out_chan.frame_byte,
                     out_chan.byte_position, out_chan.frame_last);
          end
        end
      end
    end
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
